@@ src/jhd_pkg.sv @@
// Shared types and codes for the JPEG Huffman block decoder.
// No dependencies.
package jhd_pkg;

   localparam int SymbolDepthDefault  = 256;
   localparam int MaxCodeLengthDefault = 16;

   localparam logic [1:0] CMD_LOAD_COUNT  = 2'd0;
   localparam logic [1:0] CMD_LOAD_SYMBOL = 2'd1;
   localparam logic [1:0] CMD_SCAN_BYTE   = 2'd2;
   localparam logic [1:0] CMD_RESTART     = 2'd3;

   localparam logic [2:0] STATUS_COEF      = 3'd0;
   localparam logic [2:0] STATUS_COEF_LAST = 3'd1;
   localparam logic [2:0] STATUS_EOB       = 3'd2;
   localparam logic [2:0] STATUS_ERROR     = 3'd3;
   localparam logic [2:0] STATUS_MARKER    = 3'd4;

   localparam logic [7:0] BYTE_FF     = 8'hFF;
   localparam logic [7:0] BYTE_00     = 8'h00;
   localparam logic [7:0] RST_FIRST   = 8'hD0;
   localparam logic [7:0] RST_LAST    = 8'hD7;
   localparam logic [3:0] RUN_ZRL     = 4'hF;
   localparam logic [7:0] DC_SIZE_MAX = 8'd11;
   localparam logic [6:0] BLOCK_SIZE  = 7'd64;
   localparam logic [6:0] ZRL_STEP    = 7'd16;

   typedef enum logic [2:0] {
      PH_DC_CODE, PH_DC_BITS, PH_AC_CODE, PH_AC_BITS, PH_HALT, PH_END
   } phase_type;

   typedef enum logic [1:0] {
      CTL_IDLE, CTL_BIT, CTL_SYM, CTL_FLUSH
   } ctl_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       table_select;
      logic [7:0] entry_index;
      logic [7:0] entry_value;
      logic [7:0] scan_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [5:0]         position;
      logic signed [15:0] coefficient;
      logic               last_result;
   } rsp_type;

endpackage

@@ src/jpeg_huffman_block_decoder_top.sv @@
// Top level of the JPEG baseline Huffman block decoder.
// Depends on jhd_pkg.
//
// A scan byte is shifted out one bit per cycle, unless decoding holds, into a
// canonical code matcher. After its accepting cycle, a byte holds the request
// side through its bit cycles, a symbol state per decoded symbol (the
// registered read of the symbol memory) and a closing state that moves any
// pending last result into the output register. A byte that stops decoding
// early drops its remaining bit cycles. An 0xFF prefix, a marker or a byte
// that arrives while halted goes straight to the closing state; loads and
// restarts keep the request side ready. Results of a byte leave through a
// one-deep pending stage and an output register. While the output register is
// full and another result is pending, decoding holds. With a result pending,
// the closing state also holds until the output register is free.
module jpeg_huffman_block_decoder_top
   #(
   parameter int SYMBOL_DEPTH    = jhd_pkg::SymbolDepthDefault,
   parameter int MAX_CODE_LENGTH = jhd_pkg::MaxCodeLengthDefault
   )
   (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  jhd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jhd_pkg::rsp_type rsp_data
   );
   import jhd_pkg::*;

   localparam int SymAw = $clog2(2 * SYMBOL_DEPTH);

   logic [7:0]       counts_ff [32];
   logic [7:0]       symbols [2 * SYMBOL_DEPTH];

   ctl_type          ctl_ff, ctl_in;
   phase_type        phase_ff, phase_in;
   logic [7:0]       shift_ff, shift_in;
   logic [3:0]       left_ff, left_in;
   logic             saw_ff_ff, saw_ff_in;
   logic [15:0]      pred_ff, pred_in;
   logic [5:0]       pos_ff, pos_in;
   logic [15:0]      acc_ff, acc_in;
   logic [4:0]       len_ff, len_in;
   logic [25:0]      first_ff, first_in;
   logic [11:0]      base_ff, base_in;
   logic [14:0]      val_ff, val_in;
   logic [3:0]       size_ff, size_in;
   logic             sign_ff, sign_in;
   logic [7:0]       sym_ff;
   rsp_type          pend_ff, pend_in;
   logic             pend_valid_ff, pend_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             rd_en;
   logic [SymAw-1:0] rd_addr;
   logic             wr_en;
   logic [SymAw-1:0] wr_addr;
   logic             cnt_wr_en;
   logic [4:0]       cnt_wr_addr;

   logic             res_valid;
   rsp_type          res;

   assign req_ready = (ctl_ff == CTL_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      logic        bit_v;
      logic        stall;
      logic        accept;
      logic        tbl;
      logic [15:0] acc_n;
      logic [4:0]  len_n;
      logic [7:0]  cnt;
      logic        match;
      logic [11:0] idx;
      logic [14:0] val_n;
      logic        sgn;
      logic [15:0] ext;
      logic [15:0] psum;
      logic [6:0]  ksum;
      logic        took_bit;
      logic        to_sym;

      ctl_in        = ctl_ff;
      phase_in      = phase_ff;
      shift_in      = shift_ff;
      left_in       = left_ff;
      saw_ff_in     = saw_ff_ff;
      pred_in       = pred_ff;
      pos_in        = pos_ff;
      acc_in        = acc_ff;
      len_in        = len_ff;
      first_in      = first_ff;
      base_in       = base_ff;
      val_in        = val_ff;
      size_in       = size_ff;
      sign_in       = sign_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      res_valid     = 1'b0;
      res           = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = SymAw'(req_data.entry_index)
                      + (req_data.table_select ? SymAw'(SYMBOL_DEPTH) : '0);
      cnt_wr_en     = 1'b0;
      cnt_wr_addr   = {req_data.table_select, 4'(req_data.entry_index - 8'd1)};

      bit_v    = shift_ff[7];
      stall    = pend_valid_ff && rsp_valid_ff;
      accept   = req_valid && (ctl_ff == CTL_IDLE);
      tbl      = (phase_ff == PH_AC_CODE);
      acc_n    = {acc_ff[14:0], bit_v};
      len_n    = len_ff + 5'd1;
      cnt      = counts_ff[{tbl, len_ff[3:0]}];
      match    = (cnt != 8'd0) && ({10'd0, acc_n} < first_ff + 26'(cnt));
      idx      = base_ff + 12'({10'd0, acc_n} - first_ff);
      val_n    = {val_ff[13:0], bit_v};
      sgn      = (len_ff == 5'd0) ? bit_v : sign_ff;
      ext      = sgn ? {1'b0, val_n}
                     : {1'b0, val_n} + (16'hFFFF << size_ff) + 16'd1;
      psum     = pred_ff + ext;
      ksum     = {1'b0, pos_ff} + 7'(sym_ff[7:4]);
      took_bit = 1'b0;
      to_sym   = 1'b0;

      case (ctl_ff)
         CTL_IDLE: begin
            if (accept) begin
               case (req_data.cmd)
                  CMD_LOAD_COUNT: begin
                     cnt_wr_en = (req_data.entry_index >= 8'd1)
                                 && (req_data.entry_index <= 8'd16);
                  end
                  CMD_LOAD_SYMBOL: begin
                     wr_en = {1'b0, req_data.entry_index} < 9'(SYMBOL_DEPTH);
                  end
                  CMD_RESTART: begin
                     pred_in   = '0;
                     pos_in    = '0;
                     acc_in    = '0;
                     len_in    = '0;
                     first_in  = '0;
                     base_in   = '0;
                     val_in    = '0;
                     size_in   = '0;
                     phase_in  = PH_DC_CODE;
                     saw_ff_in = 1'b0;
                  end
                  CMD_SCAN_BYTE: begin
                     ctl_in = CTL_FLUSH;
                     if (phase_ff != PH_HALT && phase_ff != PH_END) begin
                        if (saw_ff_ff) begin
                           if (req_data.scan_byte != BYTE_FF) begin
                              saw_ff_in = 1'b0;
                              if (req_data.scan_byte == BYTE_00) begin
                                 shift_in = BYTE_FF;
                                 left_in  = 4'd8;
                                 ctl_in   = CTL_BIT;
                              end else if (req_data.scan_byte < RST_FIRST
                                           || req_data.scan_byte > RST_LAST) begin
                                 res_valid  = 1'b1;
                                 res.status = STATUS_MARKER;
                                 phase_in   = PH_END;
                              end
                           end
                        end else if (req_data.scan_byte == BYTE_FF) begin
                           saw_ff_in = 1'b1;
                        end else begin
                           shift_in = req_data.scan_byte;
                           left_in  = 4'd8;
                           ctl_in   = CTL_BIT;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         CTL_BIT: begin
            if (!stall) begin
               took_bit = 1'b1;
               shift_in = {shift_ff[6:0], 1'b0};
               left_in  = left_ff - 4'd1;
               case (phase_ff)
                  PH_DC_CODE, PH_AC_CODE: begin
                     if (match) begin
                        acc_in   = '0;
                        len_in   = '0;
                        first_in = '0;
                        base_in  = '0;
                        if ({10'd0, acc_n} < first_ff
                            || idx >= 12'(SYMBOL_DEPTH)) begin
                           res_valid  = 1'b1;
                           res.status = STATUS_ERROR;
                           phase_in   = PH_HALT;
                        end else begin
                           rd_en   = 1'b1;
                           rd_addr = SymAw'(idx)
                                     + (tbl ? SymAw'(SYMBOL_DEPTH) : '0);
                           to_sym  = 1'b1;
                        end
                     end else begin
                        acc_in   = acc_n;
                        len_in   = len_n;
                        first_in = (first_ff + 26'(cnt)) << 1;
                        base_in  = base_ff + 12'(cnt);
                        if (len_n >= 5'(MAX_CODE_LENGTH)) begin
                           res_valid  = 1'b1;
                           res.status = STATUS_ERROR;
                           phase_in   = PH_HALT;
                        end
                     end
                  end
                  PH_DC_BITS, PH_AC_BITS: begin
                     val_in  = val_n;
                     len_in  = len_n;
                     sign_in = sgn;
                     if (len_n[3:0] == size_ff) begin
                        len_in    = '0;
                        val_in    = '0;
                        res_valid = 1'b1;
                        if (phase_ff == PH_DC_BITS) begin
                           pred_in         = psum;
                           res.status      = STATUS_COEF;
                           res.coefficient = psum;
                           pos_in          = 6'd1;
                           phase_in        = PH_AC_CODE;
                        end else begin
                           res.position    = pos_ff;
                           res.coefficient = ext;
                           if (pos_ff == 6'd63) begin
                              res.status = STATUS_COEF_LAST;
                              pos_in     = '0;
                              phase_in   = PH_DC_CODE;
                           end else begin
                              res.status = STATUS_COEF;
                              pos_in     = pos_ff + 6'd1;
                              phase_in   = PH_AC_CODE;
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         CTL_SYM: begin
            if (!stall) begin
               if (phase_ff == PH_DC_CODE) begin
                  if (sym_ff > DC_SIZE_MAX) begin
                     res_valid  = 1'b1;
                     res.status = STATUS_ERROR;
                     phase_in   = PH_HALT;
                  end else if (sym_ff == 8'd0) begin
                     res_valid       = 1'b1;
                     res.status      = STATUS_COEF;
                     res.coefficient = pred_ff;
                     pos_in          = 6'd1;
                     phase_in        = PH_AC_CODE;
                  end else begin
                     size_in  = sym_ff[3:0];
                     phase_in = PH_DC_BITS;
                  end
               end else if (sym_ff[3:0] == 4'd0) begin
                  if (sym_ff[7:4] == 4'd0) begin
                     res_valid  = 1'b1;
                     res.status = STATUS_EOB;
                     pos_in     = '0;
                     phase_in   = PH_DC_CODE;
                  end else if (sym_ff[7:4] == RUN_ZRL) begin
                     if ({1'b0, pos_ff} + ZRL_STEP > BLOCK_SIZE) begin
                        res_valid  = 1'b1;
                        res.status = STATUS_ERROR;
                        phase_in   = PH_HALT;
                     end else if ({1'b0, pos_ff} + ZRL_STEP == BLOCK_SIZE) begin
                        res_valid  = 1'b1;
                        res.status = STATUS_EOB;
                        pos_in     = '0;
                        phase_in   = PH_DC_CODE;
                     end else begin
                        pos_in = pos_ff + 6'(ZRL_STEP);
                     end
                  end else begin
                     res_valid  = 1'b1;
                     res.status = STATUS_ERROR;
                     phase_in   = PH_HALT;
                  end
               end else if (ksum >= BLOCK_SIZE) begin
                  res_valid  = 1'b1;
                  res.status = STATUS_ERROR;
                  phase_in   = PH_HALT;
               end else begin
                  pos_in   = ksum[5:0];
                  size_in  = sym_ff[3:0];
                  phase_in = PH_AC_BITS;
               end
               ctl_in = (left_ff == 4'd0 || phase_in == PH_HALT) ? CTL_FLUSH : CTL_BIT;
            end
         end
         CTL_FLUSH: begin
            if (!pend_valid_ff) begin
               ctl_in = CTL_IDLE;
            end else if (!rsp_valid_ff) begin
               rsp_in             = pend_ff;
               rsp_in.last_result = 1'b1;
               rsp_valid_in       = 1'b1;
               pend_valid_in      = 1'b0;
               ctl_in             = CTL_IDLE;
            end
         end
         default: ctl_in = CTL_IDLE;
      endcase

      if (took_bit) begin
         if (to_sym) begin
            ctl_in = CTL_SYM;
         end else if (left_in == 4'd0 || phase_in == PH_HALT) begin
            ctl_in = CTL_FLUSH;
         end
      end

      // hand the older result on; the new one waits to learn if it is last
      if (res_valid) begin
         if (pend_valid_ff) begin
            rsp_in       = pend_ff;
            rsp_valid_in = 1'b1;
         end
         pend_in       = res;
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff        <= CTL_IDLE;
         phase_ff      <= PH_DC_CODE;
         saw_ff_ff     <= 1'b0;
         pred_ff       <= '0;
         pos_ff        <= '0;
         acc_ff        <= '0;
         len_ff        <= '0;
         first_ff      <= '0;
         base_ff       <= '0;
         val_ff        <= '0;
         size_ff       <= '0;
         left_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < 32; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         ctl_ff        <= ctl_in;
         phase_ff      <= phase_in;
         saw_ff_ff     <= saw_ff_in;
         pred_ff       <= pred_in;
         pos_ff        <= pos_in;
         acc_ff        <= acc_in;
         len_ff        <= len_in;
         first_ff      <= first_in;
         base_ff       <= base_in;
         val_ff        <= val_in;
         size_ff       <= size_in;
         left_ff       <= left_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (cnt_wr_en) begin
            counts_ff[cnt_wr_addr] <= req_data.entry_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      sign_ff  <= sign_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         symbols[wr_addr] <= req_data.entry_value;
      end
      if (rd_en) begin
         sym_ff <= symbols[rd_addr];
      end
   end

endmodule

@@ src/jhd_checker.sv @@
// Port-level checks for the JPEG Huffman block decoder, bound to its top level.
// Depends on jhd_pkg.
module jhd_checker
   (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input jhd_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input jhd_pkg::rsp_type rsp_data
   );
   import jhd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   a_scan_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.cmd == CMD_SCAN_BYTE |=> !req_ready)
      else $error("scan byte request not held busy");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= STATUS_MARKER)
      else $error("bad status");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_EOB || rsp_data.status == STATUS_ERROR
                    || rsp_data.status == STATUS_MARKER)
      |-> rsp_data.position == 6'd0 && rsp_data.coefficient == 16'sd0)
      else $error("nonzero fields on non-coefficient result");

endmodule

bind jpeg_huffman_block_decoder_top jhd_checker u_jhd_checker (.*);
